/* design/tblpc_pkg.sv */
// Package for the two-button long-press confirm block.
// Holds the event codes, shared constants and the controller/datapath structs.
// No dependencies.
package tblpc_pkg;

  // Event codes reported with every result transaction.
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_STARTED   = 3'd1,
    EV_UPDATED   = 3'd2,
    EV_READY     = 3'd3,
    EV_CANCELLED = 3'd4,
    EV_CONFIRMED = 3'd5,
    EV_LEFT      = 3'd6,
    EV_RIGHT     = 3'd7
  } event_e;

  localparam logic [6:0]  FULL_PCT       = 7'd100;
  localparam logic [15:0] HOLD_MS_RESET  = 16'd3000;
  // The percent below the cap is less than 100, so seven quotient bits suffice.
  localparam int unsigned QUOT_W         = 7;
  localparam int unsigned STEP_W         = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);
  // Largest dividend is 65535 * 100, which fits in 23 bits.
  localparam int unsigned DIVIDEND_W     = 23;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;    // capture the input sample
    logic              mul;     // form elapsed*100 and the hold-reached compare
    logic              div;     // one restoring division step
    logic [STEP_W-1:0] step;    // quotient bit worked on in this step
    logic              commit;  // update state and load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // output register holds a result that is stalled
  } dp_status_t;

endpackage

/* design/tblpc_ctrl.sv */
// Controller of the two-button long-press confirm block.
// Sequences capture, multiply, seven division steps and commit.
// Depends on tblpc_pkg.
module tblpc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tblpc_pkg::dp_status_t  status_i,
  output tblpc_pkg::ctl_cmd_t    cmd_o
);
  import tblpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next-state logic and command decode.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        step_d    = LAST_STEP;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        if (step_q == '0) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* design/tblpc_datapath.sv */
// Datapath of the two-button long-press confirm block.
// Holds the sample, the divider, the button state, the hold time and the output register.
// Depends on tblpc_pkg.
module tblpc_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tblpc_pkg::ctl_cmd_t    cmd_i,
  output tblpc_pkg::dp_status_t  status_o,
  input  logic                   cfg_valid_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   left_pressed_i,
  input  logic                   right_pressed_i,
  input  logic                   left_released_pulse_i,
  input  logic                   right_released_pulse_i,
  input  logic [31:0]            now_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             event_code_o,
  output logic [6:0]             progress_pct_o,
  output logic                   progress_visible_o,
  output logic                   reset_screen_active_o,
  output logic                   confirm_pending_o
);
  import tblpc_pkg::*;

  // Hold time register.
  logic [15:0] hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ms_q <= HOLD_MS_RESET;
    end else if (cfg_valid_i) begin
      hold_ms_q <= cfg_data_i;
    end
  end

  // Button state.
  logic        chord_q, chord_d;
  logic        await_q, await_d;
  logic        ignore_q, ignore_d;
  logic [31:0] start_q, start_d;
  logic        prog_q, prog_d;
  logic        screen_q, screen_d;
  logic        conf_q, conf_d;
  logic [6:0]  pct_q, pct_d;

  // Captured sample; payload, no reset needed.
  logic        lp_q, rp_q, lr_q, rr_q;
  logic [31:0] now_q;
  logic [31:0] elapsed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lp_q      <= left_pressed_i;
      rp_q      <= right_pressed_i;
      lr_q      <= left_released_pulse_i;
      rr_q      <= right_released_pulse_i;
      now_q     <= now_ms_i;
      elapsed_q <= now_ms_i - start_q;
    end
  end

  // Multiply and restoring divide. Only the elapsed values below the hold
  // time use the quotient, and those fit in 16 bits.
  logic                  reached_q;
  logic [DIVIDEND_W-1:0] rem_q;
  logic [QUOT_W-1:0]     quot_q;
  logic [DIVIDEND_W-1:0] divisor;
  logic [DIVIDEND_W:0]   trial;

  assign divisor = DIVIDEND_W'(hold_ms_q) << cmd_i.step;
  assign trial   = {1'b0, rem_q} - {1'b0, divisor};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      reached_q <= (elapsed_q >= {16'd0, hold_ms_q});
      rem_q     <= DIVIDEND_W'(elapsed_q[15:0]) * DIVIDEND_W'(FULL_PCT);
      quot_q    <= '0;
    end else if (cmd_i.div) begin
      if (!trial[DIVIDEND_W]) begin
        rem_q <= trial[DIVIDEND_W-1:0];
      end
      quot_q <= {quot_q[QUOT_W-2:0], ~trial[DIVIDEND_W]};
    end
  end

  // Decision logic for one sample.
  event_e ev;
  logic   both;

  assign both = lp_q & rp_q;

  always_comb begin
    chord_d  = chord_q;
    await_d  = await_q;
    ignore_d = ignore_q;
    start_d  = start_q;
    prog_d   = prog_q;
    screen_d = screen_q;
    conf_d   = conf_q;
    pct_d    = pct_q;
    ev       = EV_NONE;
    if (both && !chord_q) begin
      // A new chord starts the progress sequence.
      chord_d  = 1'b1;
      start_d  = now_q;
      prog_d   = 1'b1;
      screen_d = 1'b1;
      conf_d   = 1'b0;
      pct_d    = '0;
      await_d  = 1'b0;
      ev       = EV_STARTED;
    end else if (chord_q && both && !conf_q) begin
      // Chord still held: report progress, or readiness once the hold is reached.
      pct_d = reached_q ? FULL_PCT : quot_q;
      if (reached_q) begin
        conf_d  = 1'b1;
        prog_d  = 1'b0;
        await_d = 1'b1;
        ev      = EV_READY;
      end else begin
        ev = EV_UPDATED;
      end
    end else if (chord_q && !both && !await_q && !conf_q) begin
      // Chord broken before the hold completed.
      screen_d = 1'b0;
      prog_d   = 1'b0;
      conf_d   = 1'b0;
      pct_d    = '0;
      chord_d  = 1'b0;
      ev       = EV_CANCELLED;
    end else if (await_q && !both) begin
      // Chord broken after completion; pending releases are dropped.
      await_d  = 1'b0;
      chord_d  = 1'b0;
      ignore_d = 1'b1;
    end else begin
      if (ignore_q && !lr_q && !rr_q) begin
        ignore_d = 1'b0;
      end
      if (!screen_q && !await_q) begin
        if (lr_q) begin
          ev = EV_LEFT;
        end else if (rr_q) begin
          ev = EV_RIGHT;
        end
      end else if (screen_q && conf_q && !await_q && !ignore_d && (lr_q || rr_q)) begin
        // Left release cancels, right release confirms; left wins a tie.
        screen_d = 1'b0;
        prog_d   = 1'b0;
        conf_d   = 1'b0;
        pct_d    = '0;
        chord_d  = 1'b0;
        ev       = lr_q ? EV_CANCELLED : EV_CONFIRMED;
      end
    end
  end

  // State registers update at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_q  <= 1'b0;
      await_q  <= 1'b0;
      ignore_q <= 1'b0;
      start_q  <= '0;
      prog_q   <= 1'b0;
      screen_q <= 1'b0;
      conf_q   <= 1'b0;
      pct_q    <= '0;
    end else if (cmd_i.commit) begin
      chord_q  <= chord_d;
      await_q  <= await_d;
      ignore_q <= ignore_d;
      start_q  <= start_d;
      prog_q   <= prog_d;
      screen_q <= screen_d;
      conf_q   <= conf_d;
      pct_q    <= pct_d;
    end
  end

  // Output register: valid flag and payload.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.commit | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      event_code_o          <= ev;
      progress_pct_o        <= pct_d;
      progress_visible_o    <= prog_d;
      reset_screen_active_o <= screen_d;
      confirm_pending_o     <= conf_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_busy = out_valid_q & out_stall_i;

endmodule

/* design/two_button_long_press_confirm.sv */
// Top level of the two-button long-press confirm block.
// Joins tblpc_ctrl and tblpc_datapath; depends on tblpc_pkg.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------------
//   input   | in_valid_i / in_stall_o | button levels, release pulses, now_ms_i
//   result  | out_valid_o/out_stall_i | event code, percent, three status flags
//   config  | cfg_valid_i/cfg_ready_o | hold time in ms (16 bits)
//
// Each sample goes from acceptance to a loaded result through multiply,
// seven steps of the restoring percent divider, then commit.
// The next sample is accepted in the cycle after commit, so no sample is taken
// before the last one is committed, while the last result may still wait in the
// output register. A stalled result holds commit back.
// Reset sets the hold time to 3000 ms and clears all button state.
module two_button_long_press_confirm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        left_pressed_i,
  input  logic        right_pressed_i,
  input  logic        left_released_pulse_i,
  input  logic        right_released_pulse_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_code_o,
  output logic [6:0]  progress_pct_o,
  output logic        progress_visible_o,
  output logic        reset_screen_active_o,
  output logic        confirm_pending_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import tblpc_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // The hold time register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  tblpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tblpc_datapath u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_data_i             (cfg_data_i),
    .left_pressed_i         (left_pressed_i),
    .right_pressed_i        (right_pressed_i),
    .left_released_pulse_i  (left_released_pulse_i),
    .right_released_pulse_i (right_released_pulse_i),
    .now_ms_i               (now_ms_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .event_code_o           (event_code_o),
    .progress_pct_o         (progress_pct_o),
    .progress_visible_o     (progress_visible_o),
    .reset_screen_active_o  (reset_screen_active_o),
    .confirm_pending_o      (confirm_pending_o)
  );

endmodule

/* design/tblpc_checker.sv */
// Port-level checker for the two-button long-press confirm block.
// Bound to two_button_long_press_confirm; no package dependency.
module tblpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] event_code_o,
  input logic [6:0] progress_pct_o,
  input logic       progress_visible_o,
  input logic       reset_screen_active_o,
  input logic       confirm_pending_o
);

  // An accepted sample keeps the input side busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again right after a transaction");

  // A stalled result stays valid and keeps its event code and percent.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(event_code_o)
      && $stable(progress_pct_o)))
    else $error("stalled result changed");

  // The percent never passes the cap.
  a_pct_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (progress_pct_o <= 7'd100))
    else $error("progress percent above 100");

  // Progress and confirmation are only shown on the reset screen.
  a_flags_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!confirm_pending_o || reset_screen_active_o)
      && (!progress_visible_o || reset_screen_active_o)))
    else $error("status flag set outside the reset screen");

endmodule

bind two_button_long_press_confirm tblpc_checker u_tblpc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .event_code_o          (event_code_o),
  .progress_pct_o        (progress_pct_o),
  .progress_visible_o    (progress_visible_o),
  .reset_screen_active_o (reset_screen_active_o),
  .confirm_pending_o     (confirm_pending_o)
);

/* sim/testbench.sv */
// Self-checking testbench for the two-button long-press confirm block.
// Drives button samples and hold-time writes, predicts every result in a scoreboard class.
// Depends on tblpc_pkg and two_button_long_press_confirm.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tblpc_pkg::*;

  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned PHASE_ITEMS   = 330;

  // One button sample as seen on the input channel.
  typedef struct {
    logic        lp;
    logic        rp;
    logic        lr;
    logic        rr;
    logic [31:0] stamp;
  } sample_t;

  // One result transaction, field by field.
  typedef struct {
    logic [2:0] code;
    logic [6:0] pct;
    logic       visible;
    logic       screen;
    logic       pending;
  } result_t;

  // Tracks the controller state, predicts each result and compares what comes out.
  class confirm_scoreboard;
    logic [15:0] hold_ms;
    bit          chord;
    bit          await_release;
    bit          skip_releases;
    logic [31:0] start_ms;
    bit          bar_shown;
    bit          screen_on;
    bit          ready;
    logic [6:0]  pct;
    result_t     expected_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned seen[8];

    function new();
      hold_ms = HOLD_MS_RESET;
      chord = 0;
      await_release = 0;
      skip_releases = 0;
      start_ms = '0;
      bar_shown = 0;
      screen_on = 0;
      ready = 0;
      pct = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_hold(logic [15:0] value);
      hold_ms = value;
    endfunction

    function int unsigned pending_count();
      return expected_results.size();
    endfunction

    function void clear_screen();
      screen_on = 0;
      bar_shown = 0;
      ready = 0;
      pct = '0;
      chord = 0;
    endfunction

    // Next state and event code for one sample.
    function event_e predict_event(sample_t s);
      bit          both;
      logic [31:0] elapsed;
      logic [63:0] quot;
      both = s.lp && s.rp;
      if (both && !chord) begin
        chord = 1;
        start_ms = s.stamp;
        bar_shown = 1;
        screen_on = 1;
        ready = 0;
        pct = '0;
        await_release = 0;
        return EV_STARTED;
      end
      // Both still held: update the percent and look for the end of the hold.
      if (chord && both && !ready) begin
        elapsed = s.stamp - start_ms;
        if (hold_ms == 16'd0) begin
          quot = 64'(FULL_PCT);
        end else begin
          quot = (64'(elapsed) * 64'd100) / 64'(hold_ms);
        end
        pct = (quot > 64'(FULL_PCT)) ? FULL_PCT : quot[6:0];
        if (elapsed >= 32'(hold_ms)) begin
          ready = 1;
          bar_shown = 0;
          await_release = 1;
          return EV_READY;
        end
        return EV_UPDATED;
      end
      if (chord && !both && !await_release && !ready) begin
        clear_screen();
        return EV_CANCELLED;
      end
      // Letting go after a completed hold ends the wait silently.
      if (await_release && !both) begin
        await_release = 0;
        chord = 0;
        skip_releases = 1;
        return EV_NONE;
      end
      if (skip_releases && !s.lr && !s.rr) begin
        skip_releases = 0;
      end
      if (!screen_on && !await_release) begin
        if (s.lr) return EV_LEFT;
        if (s.rr) return EV_RIGHT;
      end else if (screen_on && ready && !await_release && !skip_releases) begin
        if (s.lr) begin
          clear_screen();
          return EV_CANCELLED;
        end
        if (s.rr) begin
          clear_screen();
          return EV_CONFIRMED;
        end
      end
      return EV_NONE;
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      r.code = predict_event(s);
      r.pct = pct;
      r.visible = bar_shown;
      r.screen = screen_on;
      r.pending = ready;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no sample outstanding, expected none, actual code %0d",
                 $time, got.code);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (!$isunknown(got.code)) seen[got.code]++;
      compare_field("event_code", 7'(want.code), 7'(got.code));
      compare_field("progress_pct", want.pct, got.pct);
      compare_field("progress_visible", 7'(want.visible), 7'(got.visible));
      compare_field("reset_screen_active", 7'(want.screen), 7'(got.screen));
      compare_field("confirm_pending", 7'(want.pending), 7'(got.pending));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        left_pressed_i;
  logic        right_pressed_i;
  logic        left_released_pulse_i;
  logic        right_released_pulse_i;
  logic [31:0] now_ms_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  event_code_o;
  logic [6:0]  progress_pct_o;
  logic        progress_visible_o;
  logic        reset_screen_active_o;
  logic        confirm_pending_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  confirm_scoreboard sb = new();
  bit          no_idle;
  bit          stall_drawn;
  int unsigned stall_left;
  int unsigned items_sent;
  int unsigned hold_writes;
  logic [15:0] cur_hold = HOLD_MS_RESET;
  logic [31:0] stamp_ms;

  two_button_long_press_confirm dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .left_pressed_i         (left_pressed_i),
    .right_pressed_i        (right_pressed_i),
    .left_released_pulse_i  (left_released_pulse_i),
    .right_released_pulse_i (right_released_pulse_i),
    .now_ms_i               (now_ms_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .event_code_o           (event_code_o),
    .progress_pct_o         (progress_pct_o),
    .progress_visible_o     (progress_visible_o),
    .reset_screen_active_o  (reset_screen_active_o),
    .confirm_pending_o      (confirm_pending_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_data_i             (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic bit coin();
    return bit'($urandom_range(0, 1));
  endfunction

  // Result side: take each result transaction and check it.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.code = event_code_o;
      got.pct = progress_pct_o;
      got.visible = progress_visible_o;
      got.screen = reset_screen_active_o;
      got.pending = confirm_pending_o;
      sb.check_result(got);
      stall_drawn = 0;
    end
  end

  // Result side: hold off each result for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (out_valid_o && !stall_drawn) begin
      stall_left = draw_wait();
      stall_drawn = 1;
    end
    if (out_valid_o) begin
      out_stall_i = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end else begin
      out_stall_i = !no_idle && ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, sb.pending_count());
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one sample after a random gap and hold it until it is taken.
  task automatic send_sample(input bit lp, input bit rp, input bit lr, input bit rr,
                             input logic [31:0] stamp);
    int unsigned gap;
    sample_t     s;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s.lp = lp;
    s.rp = rp;
    s.lr = lr;
    s.rr = rr;
    s.stamp = stamp;
    left_pressed_i = lp;
    right_pressed_i = rp;
    left_released_pulse_i = lr;
    right_released_pulse_i = rr;
    now_ms_i = stamp;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(s);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_hold(input logic [15:0] value);
    wait_idle();
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_hold(value);
    cur_hold = value;
    hold_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // A full long-press sequence with random timing, sometimes cut short.
  task automatic hold_episode();
    int unsigned h;
    int unsigned steps;
    int unsigned p;
    h = cur_hold;
    case ($urandom_range(0, 7))
      0: stamp_ms = $urandom();
      1: stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * h + 10);
      default: stamp_ms += $urandom_range(1, 50);
    endcase
    send_sample(1, 1, coin(), coin(), stamp_ms);
    steps = $urandom_range(0, 5);
    repeat (steps) begin
      stamp_ms += $urandom_range(0, h / 4 + 1);
      send_sample(1, 1, coin(), coin(), stamp_ms);
    end
    // Early let-go cancels the hold.
    if ($urandom_range(0, 5) == 0) begin
      p = $urandom_range(0, 2);
      send_sample(p == 1, p == 2, coin(), coin(), stamp_ms + 1);
      return;
    end
    stamp_ms += h + $urandom_range(0, 3);
    send_sample(1, 1, coin(), coin(), stamp_ms);
    repeat ($urandom_range(0, 2)) begin
      stamp_ms += $urandom_range(0, 100);
      send_sample(1, 1, coin(), coin(), stamp_ms);
    end
    // Release the chord, then pulses left over from it.
    p = $urandom_range(0, 2);
    stamp_ms += $urandom_range(0, 100);
    send_sample(p == 1, p == 2, coin(), coin(), stamp_ms);
    repeat ($urandom_range(0, 2)) begin
      p = $urandom_range(0, 2);
      send_sample(p == 1, p == 2, coin(), coin(), stamp_ms);
    end
    if ($urandom_range(0, 5) == 0) return;
    stamp_ms += $urandom_range(1, 20);
    send_sample(0, 0, 0, 0, stamp_ms);
    p = $urandom_range(1, 3);
    stamp_ms += $urandom_range(1, 20);
    send_sample(0, 0, p[0], p[1], stamp_ms);
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    logic [15:0] hold_val;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    left_pressed_i = 1'b0;
    right_pressed_i = 1'b0;
    left_released_pulse_i = 1'b0;
    right_released_pulse_i = 1'b0;
    now_ms_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    stamp_ms = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single releases, both pulses at once, cancel, and a timestamp wrap.
    send_sample(0, 0, 0, 0, 32'd0);
    send_sample(0, 0, 1, 0, 32'd6);
    send_sample(0, 0, 0, 1, 32'd7);
    send_sample(0, 0, 1, 1, 32'd8);
    send_sample(1, 1, 0, 0, 32'hFFFF_FF00);
    send_sample(1, 1, 0, 0, 32'h0000_0100);
    send_sample(0, 1, 0, 0, 32'h0000_0200);
    // Full hold at the reset hold time, pulses after the chord are swallowed.
    send_sample(1, 1, 0, 0, 32'd1000);
    send_sample(1, 1, 1, 1, 32'd3999);
    send_sample(1, 1, 0, 0, 32'd4000);
    send_sample(1, 0, 0, 1, 32'd4200);
    send_sample(0, 0, 1, 0, 32'd4300);
    send_sample(0, 0, 0, 0, 32'd4400);
    send_sample(0, 0, 1, 1, 32'd4500);
    // Largest elapsed time saturates the percent; re-press on the confirm screen.
    send_sample(1, 1, 0, 0, 32'hFFFF_FFF0);
    send_sample(1, 1, 0, 0, 32'hFFFF_FFEF);
    send_sample(0, 0, 0, 0, 32'd5);
    send_sample(1, 1, 0, 0, 32'd10);
    // Zero hold time completes on the first update.
    write_hold(16'd0);
    send_sample(1, 1, 0, 0, 32'd20);
    send_sample(0, 0, 0, 0, 32'd30);
    send_sample(0, 0, 0, 0, 32'd31);
    send_sample(0, 0, 0, 1, 32'd32);
    // Longest hold time, one step short of the end and then at it.
    write_hold(16'hFFFF);
    send_sample(1, 1, 0, 0, 32'd100);
    send_sample(1, 1, 0, 0, 32'd65634);
    send_sample(1, 1, 0, 0, 32'd65635);

    // Random phases, each at its own hold time, some without any idling.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: hold_val = 16'd1;
        1: hold_val = 16'hFFFF;
        2: hold_val = 16'd0;
        3: hold_val = 16'($urandom_range(2, 40));
        4: hold_val = 16'($urandom_range(41, 400));
        default: hold_val = 16'($urandom_range(401, 65534));
      endcase
      write_hold(hold_val);
      no_idle = phase[0];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          hold_episode();
        end else begin
          stamp_ms += $urandom_range(0, 1000);
          send_sample(coin(), coin(), coin(), coin(), coin() ? $urandom() : stamp_ms);
        end
      end
    end
    no_idle = 0;
    wait_idle();

    $display("Sent %0d button samples and checked %0d results over %0d hold-time writes",
             items_sent, sb.checked, hold_writes);
    $write("Events: none %0d, started %0d, updated %0d, ready %0d, ",
           sb.seen[EV_NONE], sb.seen[EV_STARTED], sb.seen[EV_UPDATED], sb.seen[EV_READY]);
    $display("cancelled %0d, confirmed %0d, left %0d, right %0d",
             sb.seen[EV_CANCELLED], sb.seen[EV_CONFIRMED], sb.seen[EV_LEFT],
             sb.seen[EV_RIGHT]);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
